/* rtl/wfba_pkg.sv */
`default_nettype none

package wfba_pkg;

    // Fixed field widths of the item and result channels
    localparam int AMOUNT_W = 20;
    localparam int ID_W     = 5;
    localparam int STATUS_W = 2;

    // Item commands
    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_REQ = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_STORED = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_PLACED = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOFIT  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd3;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_RESP
    } wfba_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;        // capture the accepted item, restart the scan
        logic scan_issue;  // read the next table entry
        logic commit;      // apply the update and load the result register
    } wfba_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic count_zero;  // table holds no block
        logic scan_last;   // entry being read is the last stored one
        logic out_free;    // result register can take a new result
    } wfba_stat_t;

endpackage

`default_nettype wire

/* rtl/wfba_ctrl.sv */
`default_nettype none

module wfba_ctrl
    import wfba_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       cmd,
    input  wire wfba_stat_t stat,
    output wfba_cmd_t       ctl
);

    wfba_state_t state_reg;
    wfba_state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequence an item: accept, scan/drain for nonempty requests, commit
    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        ctl.load       = 1'b0;
        ctl.scan_issue = 1'b0;
        ctl.commit     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.load = 1'b1;
                    if (cmd == CMD_REQ && !stat.count_zero)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_SCAN:
            begin
                ctl.scan_issue = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (stat.out_free)
                begin
                    ctl.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/wfba_dpath.sv */
`default_nettype none

module wfba_dpath
    import wfba_pkg::*;
#(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_BITS  = 20
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cmd,
    input  wire logic [AMOUNT_W-1:0] amount,
    input  wire wfba_cmd_t           ctl,
    output wfba_stat_t               stat,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [STATUS_W-1:0]      status,
    output logic [ID_W-1:0]          chosen_id,
    output logic [AMOUNT_W-1:0]      chosen_size,
    output logic [AMOUNT_W-1:0]      leftover
);

    localparam int SW    = (SIZE_BITS < AMOUNT_W) ? SIZE_BITS : AMOUNT_W;
    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

    // Block table and flags
    logic [SW-1:0]         size_mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] used_reg;
    logic [CNT_W-1:0]      count_reg;

    // Captured item
    logic                  cmd_reg;
    logic [SW-1:0]         amt_reg;

    // Scan pipeline: read stage then compare stage
    logic [IDX_W-1:0]      scan_idx_reg;
    logic [SW-1:0]         rd_data_reg;
    logic [IDX_W-1:0]      cmp_idx_reg;
    logic                  cmp_valid_reg;
    logic                  found_reg;
    logic [IDX_W-1:0]      best_idx_reg;
    logic [SW-1:0]         best_size_reg;

    // Result register
    logic                  out_valid_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [ID_W-1:0]       id_reg;
    logic [AMOUNT_W-1:0]   size_reg;
    logic [AMOUNT_W-1:0]   left_reg;

    logic                  full;
    logic                  fits;
    logic                  take;
    logic                  mem_we;
    logic                  place;
    logic [CNT_W:0]        add_id_wide;
    logic [IDX_W:0]        best_id_wide;
    logic [SW-1:0]         left_calc;
    logic [STATUS_W-1:0]   res_status;
    logic [ID_W-1:0]       res_id;
    logic [AMOUNT_W-1:0]   res_size;
    logic [AMOUNT_W-1:0]   res_left;

    assign full   = (count_reg == CNT_W'(NUM_BLOCKS));
    assign fits   = found_reg && (best_size_reg >= amt_reg);
    assign take   = cmp_valid_reg && !used_reg[cmp_idx_reg]
                    && (!found_reg || rd_data_reg > best_size_reg);
    assign mem_we = ctl.commit && (cmd_reg == CMD_ADD) && !full;
    assign place  = ctl.commit && (cmd_reg == CMD_REQ) && fits;

    assign add_id_wide  = {1'b0, count_reg} + (CNT_W + 1)'(1);
    assign best_id_wide = {1'b0, best_idx_reg} + (IDX_W + 1)'(1);
    assign left_calc    = best_size_reg - amt_reg;

    // Form the result of the current item
    always_comb
    begin
        res_status = STAT_NOFIT;
        res_id     = '0;
        res_size   = '0;
        res_left   = '0;
        if (cmd_reg == CMD_ADD)
        begin
            if (full)
            begin
                res_status = STAT_FULL;
            end
            else
            begin
                res_status = STAT_STORED;
                res_id     = ID_W'(add_id_wide);
                res_size   = AMOUNT_W'(amt_reg);
            end
        end
        else if (fits)
        begin
            res_status = STAT_PLACED;
            res_id     = ID_W'(best_id_wide);
            res_size   = AMOUNT_W'(best_size_reg);
            res_left   = AMOUNT_W'(left_calc);
        end
    end

    // Capture the item payload
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= cmd;
            amt_reg <= SW'(amount);
        end
    end

    // Table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            size_mem[count_reg[IDX_W-1:0]] <= amt_reg;
        end
        rd_data_reg <= size_mem[scan_idx_reg];
        cmp_idx_reg <= scan_idx_reg;
    end

    // Advance the scan index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg  <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            cmp_valid_reg <= ctl.scan_issue;
            if (ctl.load)
            begin
                scan_idx_reg <= '0;
            end
            else if (ctl.scan_issue)
            begin
                scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            end
        end
    end

    // Track the largest free block, lowest id on ties
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (ctl.load)
        begin
            found_reg <= 1'b0;
        end
        else if (take)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_idx_reg  <= cmp_idx_reg;
            best_size_reg <= rd_data_reg;
        end
    end

    // Update count and used flags on commit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            used_reg  <= '0;
        end
        else
        begin
            if (mem_we)
            begin
                count_reg                       <= count_reg + CNT_W'(1);
                used_reg[count_reg[IDX_W-1:0]] <= 1'b0;
            end
            if (place)
            begin
                used_reg[best_idx_reg] <= 1'b1;
            end
        end
    end

    // Hold the result until the transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            status_reg <= res_status;
            id_reg     <= res_id;
            size_reg   <= res_size;
            left_reg   <= res_left;
        end
    end

    assign stat.count_zero = (count_reg == '0);
    assign stat.scan_last  = (CNT_W'(scan_idx_reg) == count_reg - CNT_W'(1));
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign chosen_id   = id_reg;
    assign chosen_size = size_reg;
    assign leftover    = left_reg;

endmodule

`default_nettype wire

/* rtl/worst_fit_block_allocator.sv */
// Worst-fit allocator over a table of NUM_BLOCKS fixed-size blocks.
// Input channel (in_valid/in_ready): cmd selects add (store a block of size
// amount, ids count up from 1) or request (place amount in the largest free
// block, lowest id on equal sizes). Output channel (out_valid/out_ready):
// exactly one result per item with status, chosen_id, chosen_size, leftover.
// Timing: one item at a time. An add, or a request on an empty table, is
// accepted and then committed; any other request runs, in between, the
// scan of the stored blocks, which reads one entry per cycle from the
// single memory read port, followed by one compare stage. The result
// appears in the output register the cycle after commit.
// The output register parts the two channels: a stalled receiver holds the
// result, while the next item is accepted and processed up to its commit,
// which waits until the held result transfers.
// Reset clears the block count, the used flags and the output valid; block
// sizes need no clearing since only stored entries are scanned.
`default_nettype none

module worst_fit_block_allocator
    import wfba_pkg::*;
#(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_BITS  = 20
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                cmd,
    input  wire logic [AMOUNT_W-1:0] amount,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [STATUS_W-1:0]      status,
    output logic [ID_W-1:0]          chosen_id,
    output logic [AMOUNT_W-1:0]      chosen_size,
    output logic [AMOUNT_W-1:0]      leftover
);

    wfba_cmd_t  ctl;
    wfba_stat_t stat;

    wfba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat),
        .ctl      (ctl)
    );

    wfba_dpath #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .amount      (amount),
        .ctl         (ctl),
        .stat        (stat),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .chosen_id   (chosen_id),
        .chosen_size (chosen_size),
        .leftover    (leftover)
    );

`ifndef SYNTH
    // An accepted item keeps the input closed in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input reopened right after a transfer");

    // A new result comes only from a commit, never while idle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result raised without a commit");

    // A placed request never leaves more than the block size
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STAT_PLACED) |-> (leftover <= chosen_size))
        else $error("leftover exceeds chosen block size");

    // No-fit and table-full results carry empty fields
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == STAT_NOFIT || status == STAT_FULL))
        |-> (chosen_id == '0 && chosen_size == '0 && leftover == '0))
        else $error("empty result carries data");
`endif

endmodule

`default_nettype wire

/* tb/tb.sv */
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wfba_pkg::*;

    localparam int TABLE_DEPTH  = 16;
    localparam int RANDOM_ITEMS = 575;
    localparam int CALM_ITEMS   = 100;
    localparam int HOLD_AT_ITEM = 150;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     id;
        logic [AMOUNT_W-1:0] size;
        logic [AMOUNT_W-1:0] left;
    } alloc_result_t;

    typedef struct {
        logic          op;
        logic [AMOUNT_W-1:0] amt;
        bit            typed;
        alloc_result_t res;
    } script_row_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic                cmd;
    logic [AMOUNT_W-1:0] amount;
    logic                out_valid;
    logic                out_ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     chosen_id;
    logic [AMOUNT_W-1:0] chosen_size;
    logic [AMOUNT_W-1:0] leftover;

    // Shadow copy of the block table
    logic [AMOUNT_W-1:0] shadow_size [TABLE_DEPTH];
    bit                  shadow_taken [TABLE_DEPTH];
    int                  shadow_count;

    alloc_result_t pending_results [$];
    script_row_t   directed_rows [$];
    int            mismatches;
    bit            calm;
    bit            long_hold_req;

    worst_fit_block_allocator #(
        .NUM_BLOCKS (TABLE_DEPTH),
        .SIZE_BITS  (AMOUNT_W)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .amount      (amount),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .chosen_id   (chosen_id),
        .chosen_size (chosen_size),
        .leftover    (leftover)
    );

    // Apply one item to the shadow table and return the answer it earns
    function automatic alloc_result_t allocate_worst_fit(logic op, logic [AMOUNT_W-1:0] amt);
        alloc_result_t r;
        int            best;
        r = '{STAT_NOFIT, '0, '0, '0};
        best = -1;
        if (op == CMD_ADD) begin
            if (shadow_count >= TABLE_DEPTH) begin
                r.status = STAT_FULL;
            end
            else begin
                shadow_size[shadow_count]  = amt;
                shadow_taken[shadow_count] = 1'b0;
                shadow_count++;
                r = '{STAT_STORED, ID_W'(shadow_count), amt, '0};
            end
            return r;
        end
        // Pick the largest free block, lowest id on ties
        for (int i = 0; i < shadow_count; i++) begin
            if (!shadow_taken[i] && (best < 0 || shadow_size[i] > shadow_size[best]))
                best = i;
        end
        if (best >= 0 && shadow_size[best] >= amt) begin
            shadow_taken[best] = 1'b1;
            r = '{STAT_PLACED, ID_W'(best + 1), shadow_size[best], shadow_size[best] - amt};
        end
        return r;
    endfunction

    function automatic void add_row(logic op, logic [AMOUNT_W-1:0] amt, bit typed,
                                    logic [STATUS_W-1:0] st, int id,
                                    logic [AMOUNT_W-1:0] sz, logic [AMOUNT_W-1:0] lf);
        script_row_t row;
        row.op    = op;
        row.amt   = amt;
        row.typed = typed;
        row.res   = '{st, ID_W'(id), sz, lf};
        directed_rows.push_back(row);
    endfunction

    // Offer one item and hold it until the transfer
    task automatic offer_item(logic op, logic [AMOUNT_W-1:0] amt);
        in_valid <= 1'b1;
        cmd      <= op;
        amount   <= amt;
        do @(posedge clk); while (!in_ready);
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Reset
    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Stimulus
    initial
    begin : stimulus
        alloc_result_t       r;
        logic                op;
        logic [AMOUNT_W-1:0] amt;
        logic [AMOUNT_W-1:0] top_free;
        bit                  any_free;
        int                  n_sent;

        in_valid      = 1'b0;
        cmd           = CMD_ADD;
        amount        = '0;
        calm          = 1'b0;
        long_hold_req = 1'b0;
        mismatches    = 0;
        shadow_count  = 0;
        n_sent        = 0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            shadow_size[i]  = '0;
            shadow_taken[i] = 1'b0;
        end

        // Empty table, zero sizes, extremes, ties and the exact fit
        add_row(CMD_REQ, 20'd0,       1, STAT_NOFIT,  0, 20'd0,       20'd0);
        add_row(CMD_ADD, 20'd0,       1, STAT_STORED, 1, 20'd0,       20'd0);
        add_row(CMD_REQ, 20'd0,       1, STAT_PLACED, 1, 20'd0,       20'd0);
        add_row(CMD_REQ, 20'd0,       1, STAT_NOFIT,  0, 20'd0,       20'd0);
        add_row(CMD_ADD, 20'hFFFFF,   1, STAT_STORED, 2, 20'hFFFFF,   20'd0);
        add_row(CMD_ADD, 20'hFFFFF,   1, STAT_STORED, 3, 20'hFFFFF,   20'd0);
        add_row(CMD_REQ, 20'hFFFFF,   1, STAT_PLACED, 2, 20'hFFFFF,   20'd0);
        add_row(CMD_REQ, 20'd0,       1, STAT_PLACED, 3, 20'hFFFFF,   20'hFFFFF);
        add_row(CMD_ADD, 20'd100,     1, STAT_STORED, 4, 20'd100,     20'd0);
        add_row(CMD_REQ, 20'd101,     1, STAT_NOFIT,  0, 20'd0,       20'd0);
        add_row(CMD_REQ, 20'd100,     1, STAT_PLACED, 4, 20'd100,     20'd0);
        // Fill the rest of the table
        add_row(CMD_ADD, 20'h00001,   0, STAT_STORED, 0, 20'd0, 20'd0);
        add_row(CMD_ADD, 20'h80000,   0, STAT_STORED, 0, 20'd0, 20'd0);
        add_row(CMD_ADD, 20'h7FFFF,   0, STAT_STORED, 0, 20'd0, 20'd0);
        add_row(CMD_ADD, 20'h55555,   0, STAT_STORED, 0, 20'd0, 20'd0);
        add_row(CMD_ADD, 20'hAAAAA,   0, STAT_STORED, 0, 20'd0, 20'd0);
        add_row(CMD_ADD, 20'h80000,   0, STAT_STORED, 0, 20'd0, 20'd0);
        add_row(CMD_ADD, 20'h00010,   0, STAT_STORED, 0, 20'd0, 20'd0);
        add_row(CMD_ADD, 20'h00003,   0, STAT_STORED, 0, 20'd0, 20'd0);
        add_row(CMD_ADD, 20'hFFFFE,   0, STAT_STORED, 0, 20'd0, 20'd0);
        add_row(CMD_ADD, 20'h12345,   0, STAT_STORED, 0, 20'd0, 20'd0);
        add_row(CMD_ADD, 20'hEDCBA,   0, STAT_STORED, 0, 20'd0, 20'd0);
        add_row(CMD_ADD, 20'h00000,   0, STAT_STORED, 0, 20'd0, 20'd0);
        // Table full, then a request against the full table
        add_row(CMD_ADD, 20'd5,       1, STAT_FULL,   0, 20'd0,       20'd0);
        add_row(CMD_REQ, 20'hFFFFE,   0, STAT_STORED, 0, 20'd0, 20'd0);

        @(posedge rst_n);
        @(posedge clk);

        // Walk the directed table
        foreach (directed_rows[k]) begin
            if ($urandom_range(0, 3) == 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            offer_item(directed_rows[k].op, directed_rows[k].amt);
            r = allocate_worst_fit(directed_rows[k].op, directed_rows[k].amt);
            pending_results.push_back(directed_rows[k].typed ? directed_rows[k].res : r);
            n_sent++;
        end

        // Random items, requests aimed around the largest free block
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k == HOLD_AT_ITEM)
                long_hold_req = 1'b1;
            if (k >= RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            any_free = 1'b0;
            top_free = '0;
            for (int i = 0; i < shadow_count; i++) begin
                if (!shadow_taken[i] && (!any_free || shadow_size[i] > top_free)) begin
                    top_free = shadow_size[i];
                    any_free = 1'b1;
                end
            end
            op  = ($urandom_range(0, 3) == 0) ? CMD_ADD : CMD_REQ;
            amt = AMOUNT_W'($urandom());
            if (op == CMD_REQ && any_free) begin
                case ($urandom_range(0, 4))
                    2: amt = AMOUNT_W'($urandom_range(0, int'(top_free)));
                    3: amt = top_free;
                    4: amt = top_free + 1'b1;
                    default: ;
                endcase
            end
            if (!calm && $urandom_range(0, 3) == 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            offer_item(op, amt);
            pending_results.push_back(allocate_worst_fit(op, amt));
            n_sent++;
        end
        in_valid <= 1'b0;

        // Drain the outstanding results
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    // Receiver ready: random stalls, one long hold-off, none at the end
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            else begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Check each result transfer against the oldest expectation
    always @(posedge clk)
    begin
        alloc_result_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: status %0d id %0d size %0h leftover %0h",
                       status, chosen_id, chosen_size, leftover);
                mismatches++;
            end
            else begin
                want = pending_results.pop_front();
                if (status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    mismatches++;
                end
                if (chosen_id !== want.id) begin
                    $error("chosen_id: expected %0d, got %0d", want.id, chosen_id);
                    mismatches++;
                end
                if (chosen_size !== want.size) begin
                    $error("chosen_size: expected %0h, got %0h", want.size, chosen_size);
                    mismatches++;
                end
                if (leftover !== want.left) begin
                    $error("leftover: expected %0h, got %0h", want.left, leftover);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("tb failed");
        $finish;
    end

endmodule

/* filelist.f */
rtl/wfba_pkg.sv
rtl/wfba_ctrl.sv
rtl/wfba_dpath.sv
rtl/worst_fit_block_allocator.sv
tb/tb.sv
